### hw/rtl/tlsc_pkg.sv
// Shared types, widths and helper functions for the tetrahedral stiffness block.
// Used by the front end, the multiply and divide units, the back end and the top level.
package tlsc_pkg;

    localparam int DOF_BITS = 20;

    localparam int COORD_W = 32;
    localparam int DOF_W   = 21;
    localparam int VAL_W   = 48;
    localparam int DIFF_W  = 33;
    localparam int OPD_W   = 66;
    localparam int PROD_W  = 132;
    localparam int ACC_W   = 134;
    localparam int DEN_W   = 102;
    localparam int NUM_W   = 142;
    localparam int QUO_W   = 48;

    localparam logic [DOF_W-1:0] DOF_MASK =
        (DOF_BITS >= DOF_W) ? {DOF_W{1'b1}} : DOF_W'((64'd1 << DOF_BITS) - 64'd1);

    localparam logic [VAL_W-1:0] SAT_POS     = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] SAT_NEG_MAG = {1'b1, {(VAL_W-1){1'b0}}};

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [DOF_W-1:0]          dof;
    } t_vertex;

    typedef t_vertex [3:0] t_elem;

    typedef struct packed {
        logic signed [DIFF_W-1:0] x;
        logic signed [DIFF_W-1:0] y;
        logic signed [DIFF_W-1:0] z;
    } t_vec3;

    typedef struct packed {
        logic                    start;
        logic signed [OPD_W-1:0] a;
        logic signed [OPD_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] value;
    } t_div_rsp;

    function automatic logic signed [DIFF_W-1:0] vec_comp(t_vec3 v, logic [1:0] idx);
        logic signed [DIFF_W-1:0] r;
        case (idx)
            COMP_X:  r = v.x;
            COMP_Y:  r = v.y;
            default: r = v.z;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] mod3_inc(logic [1:0] m);
        logic [1:0] r;
        case (m)
            COMP_X:  r = COMP_Y;
            COMP_Y:  r = COMP_Z;
            default: r = COMP_X;
        endcase
        return r;
    endfunction

    function automatic logic [DOF_W-1:0] dof_to_index(logic [DOF_W-1:0] dof);
        return (dof & DOF_MASK) + DOF_W'(1);
    endfunction

    function automatic t_vec3 vsub(t_vertex a, t_vertex b);
        t_vec3 r;
        r.x = DIFF_W'(a.x) - DIFF_W'(b.x);
        r.y = DIFF_W'(a.y) - DIFF_W'(b.y);
        r.z = DIFF_W'(a.z) - DIFF_W'(b.z);
        return r;
    endfunction

endpackage

### hw/rtl/tlsc_front.sv
// Front end: collects four vertices and queues each complete element for the back end.
// Depends on tlsc_pkg.
module tlsc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic signed [31:0]            i_x,
    input  logic signed [31:0]            i_y,
    input  logic signed [31:0]            i_z,
    input  logic signed [20:0]            i_dof,
    output logic                          o_full,
    input  logic                          i_q_pop,
    output logic                          o_q_valid,
    output tlsc_pkg::t_elem               o_q_head
);

    logic [1:0]        r_cnt;
    tlsc_pkg::t_vertex r_vert [3];
    tlsc_pkg::t_elem   r_q [2];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_fill;

    tlsc_pkg::t_vertex vin;
    tlsc_pkg::t_elem   n_elem;
    logic              accept;
    logic              push_q;

    always_comb begin
        vin.x   = i_x;
        vin.y   = i_y;
        vin.z   = i_z;
        vin.dof = i_dof;
        n_elem[0] = r_vert[0];
        n_elem[1] = r_vert[1];
        n_elem[2] = r_vert[2];
        n_elem[3] = vin;
    end

    // Only the fourth vertex needs queue space; the first three go to the store.
    assign o_full    = (r_cnt == 2'd3) && (r_fill == 2'd2);
    assign accept    = i_push && !o_full;
    assign push_q    = accept && (r_cnt == 2'd3);
    assign o_q_valid = (r_fill != 2'd0);
    assign o_q_head  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (accept) begin
                r_cnt <= r_cnt + 2'd1;
            end
            if (push_q) begin
                r_wr <= ~r_wr;
            end
            if (i_q_pop) begin
                r_rd <= ~r_rd;
            end
            r_fill <= r_fill + 2'(push_q) - 2'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (r_cnt != 2'd3)) begin
            r_vert[r_cnt] <= vin;
        end
        if (push_q) begin
            r_q[r_wr] <= n_elem;
        end
    end

endmodule

### hw/rtl/tlsc_mul.sv
// Shift-and-add signed multiplier, one bit of the second operand per cycle.
// Depends on tlsc_pkg.
module tlsc_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlsc_pkg::t_mul_req i_req,
    output tlsc_pkg::t_mul_rsp o_rsp
);

    logic                              r_busy;
    logic                              r_done;
    logic                              r_neg;
    logic [tlsc_pkg::PROD_W-1:0]       r_ma;
    logic [tlsc_pkg::OPD_W-1:0]        r_mb;
    logic [tlsc_pkg::PROD_W-1:0]       r_acc;
    logic signed [tlsc_pkg::PROD_W-1:0] r_prod;

    logic [tlsc_pkg::OPD_W-1:0] ua;
    logic [tlsc_pkg::OPD_W-1:0] ub;

    assign ua = i_req.a[tlsc_pkg::OPD_W-1] ? (~i_req.a + 1'b1) : i_req.a;
    assign ub = i_req.b[tlsc_pkg::OPD_W-1] ? (~i_req.b + 1'b1) : i_req.b;

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_mb == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_mb == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // The loop ends as soon as no set bits remain in the second operand.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ma  <= tlsc_pkg::PROD_W'(ua);
            r_mb  <= ub;
            r_acc <= '0;
            r_neg <= i_req.a[tlsc_pkg::OPD_W-1] ^ i_req.b[tlsc_pkg::OPD_W-1];
        end else if (r_busy) begin
            if (r_mb == '0) begin
                r_prod <= r_neg ? $signed(~r_acc + 1'b1) : $signed(r_acc);
            end else begin
                if (r_mb[0]) begin
                    r_acc <= r_acc + r_ma;
                end
                r_ma <= r_ma << 1;
                r_mb <= r_mb >> 1;
            end
        end
    end

endmodule

### hw/rtl/tlsc_div.sv
// Restoring divider producing a saturated signed Q40.8 value, one quotient bit per cycle.
// Depends on tlsc_pkg.
module tlsc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlsc_pkg::t_div_req i_req,
    output tlsc_pkg::t_div_rsp o_rsp
);

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_FIN
    } t_dv_state;

    t_dv_state                      r_state;
    logic                           r_done;
    logic [tlsc_pkg::VAL_W-1:0]     r_value;
    logic [tlsc_pkg::DEN_W-1:0]     r_den;
    logic [tlsc_pkg::DEN_W-1:0]     r_rem;
    logic [tlsc_pkg::QUO_W-1:0]     r_nlow;
    logic [tlsc_pkg::QUO_W-1:0]     r_q;
    logic [5:0]                     r_cnt;
    logic                           r_big;
    logic                           r_neg;

    logic [tlsc_pkg::DEN_W:0]       trial;
    logic                           ge;
    logic                           big_start;
    logic [tlsc_pkg::VAL_W-1:0]     mag;
    logic [tlsc_pkg::VAL_W-1:0]     fin_value;

    assign trial = {r_rem, r_nlow[tlsc_pkg::QUO_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    // A quotient that needs more than 48 bits saturates either way.
    assign big_start = {8'd0, i_req.num} >= {i_req.den, {tlsc_pkg::QUO_W{1'b0}}};

    always_comb begin
        if (!r_neg) begin
            mag       = (r_big || r_q[tlsc_pkg::QUO_W-1]) ? tlsc_pkg::SAT_POS : r_q;
            fin_value = mag;
        end else begin
            mag = (r_big || (r_q[tlsc_pkg::QUO_W-1] && (r_q[tlsc_pkg::QUO_W-2:0] != '0)))
                ? tlsc_pkg::SAT_NEG_MAG : r_q;
            fin_value = ~mag + 1'b1;
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == DV_FIN);
            case (r_state)
                DV_IDLE: begin
                    if (i_req.start) begin
                        r_den  <= i_req.den;
                        r_neg  <= i_req.neg;
                        r_big  <= big_start;
                        r_rem  <= tlsc_pkg::DEN_W'(i_req.num[tlsc_pkg::NUM_W-1:tlsc_pkg::QUO_W]);
                        r_nlow <= i_req.num[tlsc_pkg::QUO_W-1:0];
                        r_q    <= '0;
                        r_cnt  <= 6'(tlsc_pkg::QUO_W - 1);
                        r_state <= big_start ? DV_FIN : DV_RUN;
                    end
                end
                DV_RUN: begin
                    r_rem  <= ge ? tlsc_pkg::DEN_W'(trial - {1'b0, r_den})
                                 : tlsc_pkg::DEN_W'(trial);
                    r_q    <= {r_q[tlsc_pkg::QUO_W-2:0], ge};
                    r_nlow <= r_nlow << 1;
                    r_cnt  <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_state <= DV_FIN;
                    end
                end
                DV_FIN: begin
                    r_value <= fin_value;
                    r_state <= DV_IDLE;
                end
                default: begin
                    r_state <= DV_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/tlsc_back.sv
// Back end: face normals, determinant and the 4x4 stiffness entries of one element, for free vertex pairs.
// Depends on tlsc_pkg, tlsc_mul and tlsc_div.
module tlsc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  tlsc_pkg::t_elem               i_q_head,
    output logic                          o_q_pop,
    output logic [20:0]                   o_row_index,
    output logic [20:0]                   o_col_index,
    output logic signed [47:0]            o_value,
    output logic                          o_degenerate,
    output logic                          o_last,
    output logic                          o_empty,
    input  logic                          i_pop
);

    typedef enum logic [3:0] {
        B_IDLE,
        B_X1,
        B_X1W,
        B_X2,
        B_X2W,
        B_D,
        B_DW,
        B_DEN,
        B_PAIR,
        B_SA,
        B_SB,
        B_SW,
        B_DIV,
        B_DIVW,
        B_OUT
    } t_b_state;

    t_b_state                            r_state;
    logic [1:0]                          r_k;
    logic [1:0]                          r_m;
    logic [1:0]                          r_i;
    logic [1:0]                          r_j;
    tlsc_pkg::t_vec3                     r_d10;
    tlsc_pkg::t_vec3                     r_d20;
    tlsc_pkg::t_vec3                     r_d30;
    tlsc_pkg::t_vec3                     r_d21;
    tlsc_pkg::t_vec3                     r_d31;
    logic signed [tlsc_pkg::OPD_W-1:0]   r_c [4][3];
    logic [tlsc_pkg::DOF_W-1:0]          r_dof [4];
    logic [3:0]                          r_free;
    logic signed [tlsc_pkg::ACC_W-1:0]   r_acc;
    logic signed [tlsc_pkg::OPD_W-1:0]   r_opa;
    logic [tlsc_pkg::DEN_W-1:0]          r_den;
    logic                                r_degen;
    logic [tlsc_pkg::VAL_W-1:0]          r_val;
    logic [tlsc_pkg::DOF_W-1:0]          r_row;
    logic                                r_out_valid;
    logic [tlsc_pkg::DOF_W-1:0]          r_o_row;
    logic [tlsc_pkg::DOF_W-1:0]          r_o_col;
    logic [tlsc_pkg::VAL_W-1:0]          r_o_val;
    logic                                r_o_degen;
    logic                                r_o_last;

    tlsc_pkg::t_mul_req                  mul_req;
    tlsc_pkg::t_mul_rsp                  mul_rsp;
    tlsc_pkg::t_div_req                  div_req;
    tlsc_pkg::t_div_rsp                  div_rsp;

    tlsc_pkg::t_vec3                     u_sel;
    tlsc_pkg::t_vec3                     v_sel;
    logic [1:0]                          m1;
    logic [1:0]                          m2;
    logic [1:0]                          c_row;
    logic signed [tlsc_pkg::OPD_W-1:0]   c_rd;
    logic [tlsc_pkg::DOF_W-1:0]          dof_rd;
    logic [tlsc_pkg::ACC_W-1:0]          acc_mag;
    logic signed [tlsc_pkg::ACC_W-1:0]   prod_ext;
    logic [1:0]                          imax;
    logic                                last;
    logic                                pair_end;
    logic                                out_load;

    tlsc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    tlsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Edge vectors spanning the face opposite vertex k.
    always_comb begin
        case (r_k)
            2'd0:    begin u_sel = r_d31; v_sel = r_d21; end
            2'd1:    begin u_sel = r_d20; v_sel = r_d30; end
            2'd2:    begin u_sel = r_d30; v_sel = r_d10; end
            default: begin u_sel = r_d10; v_sel = r_d20; end
        endcase
    end

    assign m1       = tlsc_pkg::mod3_inc(r_m);
    assign m2       = tlsc_pkg::mod3_inc(m1);
    assign c_row    = (r_state == B_SA) ? r_i : (r_state == B_SB) ? r_j : 2'd1;
    assign c_rd     = r_c[c_row][r_m];
    assign dof_rd   = r_dof[(r_state == B_OUT) ? r_j : r_i];
    assign acc_mag  = r_acc[tlsc_pkg::ACC_W-1] ? tlsc_pkg::ACC_W'(-r_acc)
                                               : tlsc_pkg::ACC_W'(r_acc);
    assign prod_ext = tlsc_pkg::ACC_W'(mul_rsp.prod);
    assign pair_end = (r_i == 2'd3) && (r_j == 2'd3);
    assign out_load = (r_state == B_OUT) && (!r_out_valid || i_pop);

    always_comb begin
        if (r_free[3]) begin
            imax = 2'd3;
        end else if (r_free[2]) begin
            imax = 2'd2;
        end else if (r_free[1]) begin
            imax = 2'd1;
        end else begin
            imax = 2'd0;
        end
    end

    // The final entry of an element is the diagonal of the highest free vertex.
    assign last = (r_i == imax) && (r_j == imax);

    always_comb begin
        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        case (r_state)
            B_X1: begin
                mul_req.start = 1'b1;
                mul_req.a     = tlsc_pkg::OPD_W'(tlsc_pkg::vec_comp(v_sel, m2));
                mul_req.b     = tlsc_pkg::OPD_W'(tlsc_pkg::vec_comp(u_sel, m1));
            end
            B_X2: begin
                mul_req.start = 1'b1;
                mul_req.a     = tlsc_pkg::OPD_W'(tlsc_pkg::vec_comp(v_sel, m1));
                mul_req.b     = tlsc_pkg::OPD_W'(tlsc_pkg::vec_comp(u_sel, m2));
            end
            B_D: begin
                mul_req.start = 1'b1;
                mul_req.a     = c_rd;
                mul_req.b     = tlsc_pkg::OPD_W'(tlsc_pkg::vec_comp(r_d10, r_m));
            end
            B_SB: begin
                mul_req.start = 1'b1;
                mul_req.a     = r_opa;
                mul_req.b     = c_rd;
            end
            default: begin
                mul_req.start = 1'b0;
            end
        endcase
    end

    assign div_req.start = (r_state == B_DIV);
    assign div_req.num   = tlsc_pkg::NUM_W'(acc_mag) << 8;
    assign div_req.den   = r_den;
    assign div_req.neg   = r_acc[tlsc_pkg::ACC_W-1];

    assign o_q_pop      = (r_state == B_IDLE) && i_q_valid;
    assign o_empty      = !r_out_valid;
    assign o_row_index  = r_o_row;
    assign o_col_index  = r_o_col;
    assign o_value      = r_o_val;
    assign o_degenerate = r_o_degen;
    assign o_last       = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_q_valid) begin
                        r_d10 <= tlsc_pkg::vsub(i_q_head[1], i_q_head[0]);
                        r_d20 <= tlsc_pkg::vsub(i_q_head[2], i_q_head[0]);
                        r_d30 <= tlsc_pkg::vsub(i_q_head[3], i_q_head[0]);
                        r_d21 <= tlsc_pkg::vsub(i_q_head[2], i_q_head[1]);
                        r_d31 <= tlsc_pkg::vsub(i_q_head[3], i_q_head[1]);
                        for (int n = 0; n < 4; n++) begin
                            r_dof[n]  <= i_q_head[n].dof;
                            r_free[n] <= !i_q_head[n].dof[tlsc_pkg::DOF_W-1];
                        end
                        r_k     <= 2'd0;
                        r_m     <= 2'd0;
                        r_state <= B_X1;
                    end
                end
                B_X1: begin
                    r_state <= B_X1W;
                end
                B_X1W: begin
                    if (mul_rsp.done) begin
                        r_acc   <= prod_ext;
                        r_state <= B_X2;
                    end
                end
                B_X2: begin
                    r_state <= B_X2W;
                end
                B_X2W: begin
                    if (mul_rsp.done) begin
                        r_c[r_k][r_m] <= tlsc_pkg::OPD_W'(r_acc - prod_ext);
                        if (r_m == 2'd2) begin
                            r_m <= 2'd0;
                            if (r_k == 2'd3) begin
                                r_acc   <= '0;
                                r_state <= B_D;
                            end else begin
                                r_k     <= r_k + 2'd1;
                                r_state <= B_X1;
                            end
                        end else begin
                            r_m     <= r_m + 2'd1;
                            r_state <= B_X1;
                        end
                    end
                end
                B_D: begin
                    r_state <= B_DW;
                end
                B_DW: begin
                    if (mul_rsp.done) begin
                        r_acc <= r_acc + prod_ext;
                        if (r_m == 2'd2) begin
                            r_m     <= 2'd0;
                            r_state <= B_DEN;
                        end else begin
                            r_m     <= r_m + 2'd1;
                            r_state <= B_D;
                        end
                    end
                end
                B_DEN: begin
                    r_den   <= tlsc_pkg::DEN_W'((acc_mag << 2) + (acc_mag << 1));
                    r_degen <= (r_acc == '0);
                    r_i     <= 2'd0;
                    r_j     <= 2'd0;
                    r_state <= B_PAIR;
                end
                B_PAIR: begin
                    r_row <= tlsc_pkg::dof_to_index(dof_rd);
                    if (r_free[r_i] && r_free[r_j]) begin
                        if (r_degen) begin
                            r_val   <= '0;
                            r_state <= B_OUT;
                        end else begin
                            r_m     <= 2'd0;
                            r_acc   <= '0;
                            r_state <= B_SA;
                        end
                    end else if (pair_end) begin
                        r_state <= B_IDLE;
                    end else begin
                        {r_i, r_j} <= {r_i, r_j} + 4'd1;
                    end
                end
                B_SA: begin
                    r_opa   <= c_rd;
                    r_state <= B_SB;
                end
                B_SB: begin
                    r_state <= B_SW;
                end
                B_SW: begin
                    if (mul_rsp.done) begin
                        r_acc <= r_acc + prod_ext;
                        if (r_m == 2'd2) begin
                            r_state <= B_DIV;
                        end else begin
                            r_m     <= r_m + 2'd1;
                            r_state <= B_SA;
                        end
                    end
                end
                B_DIV: begin
                    r_state <= B_DIVW;
                end
                B_DIVW: begin
                    if (div_rsp.done) begin
                        r_val   <= div_rsp.value;
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (out_load) begin
                        r_o_row     <= r_row;
                        r_o_col     <= tlsc_pkg::dof_to_index(dof_rd);
                        r_o_val     <= r_val;
                        r_o_degen   <= r_degen;
                        r_o_last    <= last;
                        if (pair_end) begin
                            r_state <= B_IDLE;
                        end else begin
                            {r_i, r_j} <= {r_i, r_j} + 4'd1;
                            r_state    <= B_PAIR;
                        end
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/tet_laplace_stiffness_coo.sv
// Linear tetrahedron Laplacian stiffness in coordinate form; vertices in, entries out.
// Face normals and determinant come from the shared bit-serial multiplier; each free entry
// then takes three 66-bit multiplies and a 48-step divide, while a degenerate element
// skips both and gives zero entries. The front end queues up to two complete elements
// while the back end works on one.
// Reset is synchronous and active low; it empties the element queue and the output register.
module tet_laplace_stiffness_coo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_z,
    input  logic signed [20:0] i_dof,
    output logic               empty,
    input  logic               pop,
    output logic [20:0]        o_row_index,
    output logic [20:0]        o_col_index,
    output logic signed [47:0] o_value,
    output logic               o_degenerate,
    output logic               o_last
);

    logic            q_valid;
    logic            q_pop;
    tlsc_pkg::t_elem q_head;

    tlsc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_x       (i_x),
        .i_y       (i_y),
        .i_z       (i_z),
        .i_dof     (i_dof),
        .o_full    (full),
        .i_q_pop   (q_pop),
        .o_q_valid (q_valid),
        .o_q_head  (q_head)
    );

    tlsc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_head     (q_head),
        .o_q_pop      (q_pop),
        .o_row_index  (o_row_index),
        .o_col_index  (o_col_index),
        .o_value      (o_value),
        .o_degenerate (o_degenerate),
        .o_last       (o_last),
        .o_empty      (empty),
        .i_pop        (pop)
    );

endmodule

### hw/rtl/tlsc_checker.sv
// Port-level checks for the tetrahedral stiffness block, bound to the top level.
// Depends only on the top-level ports.
module tlsc_props (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               empty,
    input logic               pop,
    input logic [20:0]        o_row_index,
    input logic [20:0]        o_col_index,
    input logic signed [47:0] o_value,
    input logic               o_degenerate,
    input logic               o_last
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_degenerate) |-> (o_value == 48'sd0))
        else $error("degenerate entry with nonzero value");

    a_index_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_row_index != 21'd0) && (o_col_index != 21'd0)))
        else $error("zero row or column index");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_value) && $stable(o_last)))
        else $error("waiting result changed");

endmodule

bind tet_laplace_stiffness_coo tlsc_props u_tlsc_props (.*);

### verif/tlsc_checker.sv
// Checker for tet_laplace_stiffness_coo: watches the vertex and entry queues, keeps its own
// copy of the four-vertex element store and predicts every emitted COO entry exactly.
// Depends on tlsc_pkg for the dof mask and the saturation limits.
module tlsc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic               full,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_z,
    input  logic signed [20:0] i_dof,
    input  logic               empty,
    input  logic               pop,
    input  logic [20:0]        o_row_index,
    input  logic [20:0]        o_col_index,
    input  logic signed [47:0] o_value,
    input  logic               o_degenerate,
    input  logic               o_last,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_entries,
    output int                 o_elements
);

    typedef logic signed [199:0] t_wide;

    typedef struct {
        logic [20:0] row;
        logic [20:0] col;
        logic [47:0] value;
        logic        degenerate;
        logic        last;
    } t_entry;

    t_entry             entry_q[$];
    logic signed [31:0] corner[4][3];
    logic [20:0]        corner_dof[4];
    logic [1:0]         corner_count;
    t_wide              face_normal[4][3];

    assign o_pending = entry_q.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("ERROR %s: got %0h, expected %0h at entry %0d", what, got, want, o_entries);
        o_errors++;
    endtask

    // Face normal k (twice the half normal) as (Pa1 - Pa0) x (Pb1 - Pb0).
    function automatic void face_cross(input int k, input int a1, input int a0,
                                       input int b1, input int b0);
        t_wide u[3];
        t_wide v[3];
        for (int m = 0; m < 3; m++) begin
            u[m] = t_wide'(corner[a1][m]) - t_wide'(corner[a0][m]);
            v[m] = t_wide'(corner[b1][m]) - t_wide'(corner[b0][m]);
        end
        face_normal[k][0] = u[1] * v[2] - u[2] * v[1];
        face_normal[k][1] = u[2] * v[0] - u[0] * v[2];
        face_normal[k][2] = u[0] * v[1] - u[1] * v[0];
    endfunction

    function automatic logic [47:0] stiffness(input int i, input int j, input t_wide den);
        t_wide       s;
        logic [199:0] mag;
        logic [199:0] q;
        s = (face_normal[i][0] * face_normal[j][0] + face_normal[i][1] * face_normal[j][1]
             + face_normal[i][2] * face_normal[j][2]) * 256;
        mag = s[199] ? -s : s;
        q = mag / den;
        if (!s[199])
            return (q > 200'(tlsc_pkg::SAT_POS)) ? tlsc_pkg::SAT_POS : q[47:0];
        if (q > 200'(tlsc_pkg::SAT_NEG_MAG))
            q = 200'(tlsc_pkg::SAT_NEG_MAG);
        return -q[47:0];
    endfunction

    function automatic void predict_element();
        t_wide  det;
        t_wide  den;
        logic   degen;
        t_entry e;
        int     before_size;
        face_cross(0, 3, 1, 2, 1);
        face_cross(1, 2, 0, 3, 0);
        face_cross(2, 3, 0, 1, 0);
        face_cross(3, 1, 0, 2, 0);
        det = 0;
        for (int m = 0; m < 3; m++)
            det += (t_wide'(corner[1][m]) - t_wide'(corner[0][m])) * face_normal[1][m];
        degen = (det == 0);
        den = (det < 0 ? -det : det) * 6;
        before_size = entry_q.size();
        for (int i = 0; i < 4; i++) begin
            if (corner_dof[i][20]) continue;
            for (int j = 0; j < 4; j++) begin
                if (corner_dof[j][20]) continue;
                e.row = 21'((corner_dof[i] & tlsc_pkg::DOF_MASK) + 21'd1);
                e.col = 21'((corner_dof[j] & tlsc_pkg::DOF_MASK) + 21'd1);
                e.value = degen ? 48'd0 : stiffness(i, j, den);
                e.degenerate = degen;
                e.last = 1'b0;
                entry_q.push_back(e);
            end
        end
        if (entry_q.size() > before_size)
            entry_q[entry_q.size() - 1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_entry e;
        if (!i_rst_n) begin
            corner_count <= 2'd0;
            o_errors = 0;
            o_entries = 0;
            o_elements = 0;
            entry_q.delete();
        end else begin
            if (pop && !empty) begin
                if (entry_q.size() == 0) begin
                    report("unexpected entry row", 64'(o_row_index), 64'd0);
                end else begin
                    e = entry_q.pop_front();
                    if (o_row_index !== e.row) report("row_index", 64'(o_row_index), 64'(e.row));
                    if (o_col_index !== e.col) report("col_index", 64'(o_col_index), 64'(e.col));
                    if (o_value !== e.value) report("value", 64'(o_value), 64'(e.value));
                    if (o_degenerate !== e.degenerate)
                        report("degenerate", 64'(o_degenerate), 64'(e.degenerate));
                    if (o_last !== e.last) report("last", 64'(o_last), 64'(e.last));
                end
                o_entries++;
            end
            if (push && !full) begin
                corner[corner_count][0] = i_x;
                corner[corner_count][1] = i_y;
                corner[corner_count][2] = i_z;
                corner_dof[corner_count] = i_dof;
                if (corner_count == 2'd3) begin
                    predict_element();
                    o_elements++;
                end
                corner_count <= corner_count + 2'd1;
            end
        end
    end
endmodule

### verif/testbench.sv
// Top of the tet_laplace_stiffness_coo testbench: clock, reset, vertex stimulus in random
// bursts, a stalling entry consumer, a watchdog and the verdict. Uses tlsc_checker.
module testbench;
    localparam int IDLE_LIMIT = 40000;
    localparam int DRAIN_CYCLES = 3000;
    localparam int RANDOM_ELEMENTS = 70;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic signed [31:0] i_x;
    logic signed [31:0] i_y;
    logic signed [31:0] i_z;
    logic signed [20:0] i_dof;
    logic               empty;
    logic               pop;
    logic [20:0]        o_row_index;
    logic [20:0]        o_col_index;
    logic signed [47:0] o_value;
    logic               o_degenerate;
    logic               o_last;
    int                 errors;
    int                 pending;
    int                 entries;
    int                 elements;
    int                 idle_cycles;
    int                 burst_left;
    int                 pop_mode;
    logic signed [31:0] pt[4][3];
    logic [20:0]        pt_dof[4];

    tet_laplace_stiffness_coo i_dut (.*);

    tlsc_checker i_checker (
        .*, .o_errors(errors), .o_pending(pending), .o_entries(entries), .o_elements(elements)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // The consumer switches between free flow, random stalls and long stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop_mode <= 0;
            pop <= 1'b0;
        end else begin
            if (($urandom & 63) == 0) pop_mode <= $urandom_range(0, 2);
            case (pop_mode)
                0:       pop <= 1'b1;
                1:       pop <= $urandom_range(0, 1);
                default: pop <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("tet_laplace_stiffness_coo: mismatch");
                $finish;
            end
        end
    end

    task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic [20:0] d);
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 6);
        end
        i_x <= x;
        i_y <= y;
        i_z <= z;
        i_dof <= d;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        burst_left--;
    endtask

    task automatic send_element();
        for (int k = 0; k < 4; k++)
            send_vertex(pt[k][0], pt[k][1], pt[k][2], pt_dof[k]);
    endtask

    function automatic void set_point(input int k, input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z, input logic [20:0] d);
        pt[k][0] = x;
        pt[k][1] = y;
        pt[k][2] = z;
        pt_dof[k] = d;
    endfunction

    function automatic logic [20:0] random_dof();
        case ($urandom_range(0, 9))
            0:       return 21'h1FFFFF;
            1:       return 21'($urandom);
            2:       return 21'h0FFFFF;
            default: return 21'($urandom_range(0, 21'h0FFFFF));
        endcase
    endfunction

    function automatic void random_element();
        int kind;
        int span;
        kind = $urandom_range(0, 19);
        span = ($urandom_range(0, 1) == 0) ? 32'h40000 : 32'h400;
        for (int k = 0; k < 4; k++) begin
            pt_dof[k] = random_dof();
            for (int m = 0; m < 3; m++) begin
                if (kind < 3)
                    pt[k][m] = $urandom;
                else
                    pt[k][m] = 32'($signed($urandom_range(0, 2 * span)) - span);
            end
        end
        if (kind == 3 || kind == 4) begin
            // Coplanar vertices give a zero determinant.
            for (int k = 0; k < 4; k++) pt[k][2] = pt[0][2];
        end else if (kind == 5) begin
            for (int m = 0; m < 3; m++) pt[3][m] = pt[1][m];
        end else if (kind == 6) begin
            // Wide but nearly flat element drives the entries toward saturation.
            pt[3][2] = pt[0][2] + 32'd1;
            for (int k = 0; k < 3; k++) pt[k][2] = pt[0][2];
            pt[1][0] = 32'h7FFF0000;
            pt[2][1] = 32'h80010000;
        end
    endfunction

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_x = '0;
        i_y = '0;
        i_z = '0;
        i_dof = '0;
        burst_left = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Unit tetrahedron, all vertices free.
        set_point(0, 0, 0, 0, 21'd0);
        set_point(1, 32'h10000, 0, 0, 21'd1);
        set_point(2, 0, 32'h10000, 0, 21'd2);
        set_point(3, 0, 0, 32'h10000, 21'd3);
        send_element();
        // Collapsed element that includes the largest free dof number.
        set_point(0, 32'h12345, 32'h6789, 32'hFFFF0000, 21'h0FFFFF);
        set_point(1, 32'h12345, 32'h6789, 32'hFFFF0000, 21'h0FFFFE);
        set_point(2, 32'h12345, 32'h6789, 32'hFFFF0000, 21'h0AAAAA);
        set_point(3, 32'h12345, 32'h6789, 32'hFFFF0000, 21'h055555);
        send_element();
        // Constrained vertices: minus one and the most negative dof.
        set_point(0, 0, 0, 0, 21'h1FFFFF);
        set_point(1, 32'h20000, 0, 0, 21'd7);
        set_point(2, 0, 32'h30000, 0, 21'h100000);
        set_point(3, 32'hFFFF0000, 32'hFFFF0000, 32'h8000, 21'd9);
        send_element();
        // Every vertex constrained: no entries at all.
        set_point(0, 0, 0, 0, 21'h1FFFFF);
        set_point(1, 32'h10000, 0, 0, 21'h1FFFFF);
        set_point(2, 0, 32'h10000, 0, 21'h1ABCDE);
        set_point(3, 0, 0, 32'h10000, 21'h100000);
        send_element();
        // Coordinate extremes.
        set_point(0, 32'h80000000, 32'h80000000, 32'h80000000, 21'd0);
        set_point(1, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 21'd1);
        set_point(2, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 21'd2);
        set_point(3, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 21'd3);
        send_element();
        // Huge, very flat element so entries saturate both ways.
        set_point(0, 32'h80000000, 0, 0, 21'd10);
        set_point(1, 32'h7FFFFFFF, 0, 0, 21'd11);
        set_point(2, 0, 32'h7FFFFFFF, 0, 21'd12);
        set_point(3, 0, 0, 32'd1, 21'd13);
        send_element();

        for (int n = 0; n < RANDOM_ELEMENTS; n++) begin
            random_element();
            send_element();
        end
        push <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d elements and checked %0d stiffness entries", elements, entries);
        if (errors == 0 && pending == 0) begin
            $display("tet_laplace_stiffness_coo: match");
        end else begin
            $display("tet_laplace_stiffness_coo: mismatch");
        end
        $finish;
    end
endmodule
